// File: rtl/pcd_pkg.sv
package pcd_pkg;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned CHAN_W   = 3;
  localparam int unsigned LEVEL_W  = 16;
  localparam int unsigned GATE_W   = 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK       = 2'd0,
    OP_ZERO_CROSS = 2'd1,
    OP_WRITE      = 2'd2,
    OP_READ       = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [CHAN_W-1:0]   channel;
    logic [LEVEL_W-1:0]  level;
  } cmd_t;

  typedef struct packed {
    logic [GATE_W-1:0]   gates;
    logic [LEVEL_W-1:0]  read_level;
  } rsp_t;

endpackage

// File: rtl/pcd_core.sv
module pcd_core #(
  parameter int unsigned CHANNELS   = 8,
  parameter int unsigned LEVEL_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          acc,
  input  pcd_pkg::cmd_t cmd,
  output pcd_pkg::rsp_t rsp
);
  import pcd_pkg::*;

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef logic [LEVEL_BITS-1:0] level_t;

  localparam level_t LEVEL_MAX = '1;

  level_t                pending [CHANNELS];
  level_t                active  [CHANNELS];
  level_t                elapsed;
  level_t                elapsed_next;
  logic                  armed;
  logic                  armed_next;
  logic [CHANNELS-1:0]   gate_bits;
  logic [CHANNELS-1:0]   gate_bits_next;
  logic [CHANNELS-1:0]   fire;
  logic [IDX_W-1:0]      idx;
  logic                  in_range;
  level_t                wr_level;
  level_t                rd_level;

  assign idx      = IDX_W'(cmd.channel);
  assign in_range = (32'(cmd.channel) < CHANNELS);
  assign wr_level = LEVEL_BITS'(cmd.level);

  // parallel compare against the count before this tick's increment
  always_comb begin
    for (int k = 0; k < CHANNELS; k++) begin
      fire[k] = (active[k] != LEVEL_MAX) && (elapsed >= active[k]);
    end
  end

  always_comb begin
    gate_bits_next = gate_bits;
    elapsed_next   = elapsed;
    armed_next     = armed;
    rd_level       = '0;
    case (cmd.opcode)
      OP_TICK: begin
        if (armed) begin
          gate_bits_next = gate_bits | fire;
          if (elapsed != LEVEL_MAX) begin
            elapsed_next = elapsed + level_t'(1);
          end
        end
      end
      OP_ZERO_CROSS: begin
        gate_bits_next = '0;
        elapsed_next   = '0;
        armed_next     = 1'b1;
      end
      OP_READ: begin
        if (in_range) begin
          rd_level = pending[idx];
        end
      end
      default: ;
    endcase
  end

  assign rsp.gates      = GATE_W'(gate_bits_next);
  assign rsp.read_level = LEVEL_W'(rd_level);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CHANNELS; k++) begin
        pending[k] <= LEVEL_MAX;
        active[k]  <= LEVEL_MAX;
      end
      elapsed   <= '0;
      armed     <= 1'b0;
      gate_bits <= '0;
    end else if (acc) begin
      elapsed   <= elapsed_next;
      armed     <= armed_next;
      gate_bits <= gate_bits_next;
      if (cmd.opcode == OP_ZERO_CROSS) begin
        // page swap: pending set becomes active for this half-cycle
        for (int k = 0; k < CHANNELS; k++) begin
          active[k] <= pending[k];
        end
      end
      if (cmd.opcode == OP_WRITE && in_range) begin
        pending[idx] <= wr_level;
      end
    end
  end

  a_idle_until_armed: assert property (@(posedge clk) disable iff (rst)
    !armed |-> (gate_bits == '0 && elapsed == '0))
    else $error("gates or counter moved before first zero cross");

  a_zero_cross_restart: assert property (@(posedge clk) disable iff (rst)
    acc && cmd.opcode == OP_ZERO_CROSS |=> (gate_bits == '0 && elapsed == '0 && armed))
    else $error("zero cross did not restart the half-cycle");

  a_gates_latch: assert property (@(posedge clk) disable iff (rst)
    acc && cmd.opcode != OP_ZERO_CROSS |=>
      ((gate_bits & $past(gate_bits)) == $past(gate_bits)))
    else $error("gate dropped without zero cross");

endmodule

// File: rtl/pcd_obuf.sv
module pcd_obuf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pcd_pkg::rsp_t push_data,
  output logic          ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output pcd_pkg::rsp_t rsp
);
  import pcd_pkg::*;

  rsp_t main;
  rsp_t skid;
  logic main_valid;
  logic skid_valid;
  logic pop;

  assign pop       = main_valid && rsp_ready;
  assign ready     = !skid_valid;
  assign rsp_valid = main_valid;
  assign rsp       = main;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      main <= skid;
    end else if (push && (pop || !main_valid)) begin
      main <= push_data;
    end
    if (push && main_valid && !pop) begin
      skid <= push_data;
    end
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid word held with empty output register");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    push && main_valid && !pop |=> skid_valid)
    else $error("word pushed under stall was not parked");

  a_rsp_held: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("rsp word changed or dropped while stalled");

endmodule

// File: rtl/phase_control_dimmer_8ch_core.sv
// Eight-channel phase-angle dimmer.
// cmd channel (cmd_valid/cmd_ready, cmd): one word per event - tick, zero
//   cross, level write or level read (channel, level).
// rsp channel (rsp_valid/rsp_ready, rsp): exactly one word per cmd word,
//   carrying the gate bits after that event and, on a read, the pending
//   level of the addressed channel (zero otherwise).
// The response to a cmd word is registered in the output buffer when the
//   word is accepted. Throughput: one word per cycle while rsp is taken.
// Each word is decoded and applied to the channel state in the accept
//   cycle; the response goes into a two-word output buffer (register plus
//   skid), so cmd_ready depends only on whether the skid slot is full.
// Receiver stall: one more cmd word is absorbed into the skid slot, then
//   cmd_ready drops until rsp drains. No word is dropped or repeated.
// Reset: all levels all-ones (off), counter zero, gates off, not armed.
//   Ticks do nothing until the first zero cross. No clearing pass.
module phase_control_dimmer_8ch_core #(
  parameter int unsigned CHANNELS   = 8,
  parameter int unsigned LEVEL_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  pcd_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output pcd_pkg::rsp_t rsp
);
  import pcd_pkg::*;

  logic acc;
  rsp_t result;

  assign acc = cmd_valid && cmd_ready;

  pcd_core #(
    .CHANNELS   (CHANNELS),
    .LEVEL_BITS (LEVEL_BITS)
  ) u_core (
    .clk (clk),
    .rst (rst),
    .acc (acc),
    .cmd (cmd),
    .rsp (result)
  );

  pcd_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (acc),
    .push_data (result),
    .ready     (cmd_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
